### hdl/sfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Smallest free ID allocator package
// Shared widths, limits, transfer structs and the sequencer state type for
// the smallest free identifier allocator.
// ----------------------------------------------------------------------------
package sfa_pkg;

	// Largest identifier the allocator hands out.
	localparam int unsigned MAX_VALUE  = 1023;
	// Width of one identifier and of a heap index.
	localparam int unsigned ID_W       = 10;
	// Width of the fresh counter, which must hold MAX_VALUE + 1.
	localparam int unsigned CNT_W      = 11;
	// Heap entries and membership bits.
	localparam int unsigned HEAP_DEPTH = MAX_VALUE;
	localparam int unsigned MB_DEPTH   = 2 ** ID_W;

	localparam logic [CNT_W-1:0] FRESH_RESET = CNT_W'(1);
	localparam logic [CNT_W-1:0] FRESH_LIMIT = CNT_W'(MAX_VALUE);
	localparam logic [CNT_W-1:0] FRESH_SAT   = CNT_W'(MAX_VALUE + 1);

	// Request kinds.
	localparam logic FUNC_POP  = 1'b0;
	localparam logic FUNC_GIVE = 1'b1;

	// One request transfer.
	typedef struct packed {
		logic            func;
		logic [ID_W-1:0] num;
	} sfa_req_t;

	// One result transfer.
	typedef struct packed {
		logic [ID_W-1:0] value;
		logic            exhausted;
	} sfa_rsp_t;

	// Access controls from the sequencer to the storage.
	typedef struct packed {
		logic            heap_we;
		logic [ID_W-1:0] heap_waddr;
		logic [ID_W-1:0] heap_wdata;
		logic [ID_W-1:0] heap_raddr;
		logic            mb_we;
		logic [ID_W-1:0] mb_waddr;
		logic            mb_wdata;
		logic [ID_W-1:0] mb_raddr;
	} sfa_mem_req_t;

	// Registered read data and status from the storage.
	typedef struct packed {
		logic [ID_W-1:0] heap_rdata;
		logic            mb_rdata;
		logic            clr_busy;
	} sfa_mem_rsp_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GB_CHK,
		ST_UP_RD,
		ST_UP_CMP,
		ST_POP_TOP,
		ST_POP_LAST,
		ST_DN_L,
		ST_DN_R,
		ST_DN_CMP
	} sfa_state_t;

endpackage
`default_nettype wire

### hdl/sfa_cmp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared magnitude comparator
// The single compare unit that the sequencer steers through every range
// check and every heap key compare.
// ----------------------------------------------------------------------------
module sfa_cmp
	import sfa_pkg::*;
(
	input  wire logic [CNT_W-1:0] a,
	input  wire logic [CNT_W-1:0] b,
	output logic                  lt
);

	// Unsigned less-than.
	always_comb begin
		lt = (a < b);
	end

endmodule
`default_nettype wire

### hdl/sfa_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heap and membership storage
// Holds the heap array and the membership bits, each with one write and one
// registered read per cycle. Clears the membership bits in a sweep after reset.
// ----------------------------------------------------------------------------
module sfa_mem
	import sfa_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire sfa_mem_req_t req,
	output sfa_mem_rsp_t      rsp
);

	logic [ID_W-1:0] heap_mem [HEAP_DEPTH];
	logic            mb_mem   [MB_DEPTH];
	logic [ID_W-1:0] heap_rdata_q;
	logic            mb_rdata_q;
	logic [ID_W-1:0] clr_idx_q;
	logic            clr_busy_q;

	// Clearing sweep over the membership bits, one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Heap array: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (req.heap_we) begin
			heap_mem[req.heap_waddr] <= req.heap_wdata;
		end
		heap_rdata_q <= heap_mem[req.heap_raddr];
	end

	// Membership bits: the clearing sweep takes the write port while it runs.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mb_mem[clr_idx_q] <= 1'b0;
		end else if (req.mb_we) begin
			mb_mem[req.mb_waddr] <= req.mb_wdata;
		end
		mb_rdata_q <= mb_mem[req.mb_raddr];
	end

	always_comb begin
		rsp.heap_rdata = heap_rdata_q;
		rsp.mb_rdata   = mb_rdata_q;
		rsp.clr_busy   = clr_busy_q;
	end

endmodule
`default_nettype wire

### hdl/smallest_free_id_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Smallest free identifier allocator
// Hands out the smallest free identifier from a min-heap of returned
// identifiers, or from a fresh counter when the heap is empty.
//
//   Channel  Signals               Direction  Transfer
//   request  start, busy, req      in         start high while busy low
//   result   done, result          out        done high for one cycle
//
// A pop with an empty heap is answered from the fresh counter. A pop from the heap
// reads the root and, unless that empties the heap, moves the last entry to the
// root and sifts it down one level at a time.
// A give-back is checked first and, unless it is ignored, sifted up level by level.
// After reset, busy stays high while the membership bits clear.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module smallest_free_id_allocator_core
	import sfa_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire sfa_req_t req,
	output logic          done,
	output sfa_rsp_t      result
);

	sfa_state_t      state_q, state_d;
	logic [CNT_W-1:0] fresh_q;
	logic [ID_W-1:0] count_q;
	logic [ID_W-1:0] idx_q;
	logic [ID_W-1:0] key_q;
	logic [ID_W-1:0] min_q;
	logic [ID_W-1:0] m_q;
	logic            done_q;
	sfa_rsp_t        result_q;

	sfa_mem_req_t    mem_req;
	sfa_mem_rsp_t    mem_rsp;
	logic [CNT_W-1:0] cmp_a, cmp_b;
	logic            lt;

	logic            accept;
	logic [ID_W-1:0] parent_idx;
	logic [CNT_W-1:0] left_w, right_w, count_w;
	logic            has_left, has_right;
	logic [ID_W-1:0] sel_v, sel_m;
	logic            sel_moves;
	logic            gb_ok;

	sfa_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rsp    (mem_rsp)
	);

	sfa_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.lt (lt)
	);

	assign busy   = (state_q != ST_IDLE) || mem_rsp.clr_busy;
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	// Heap index arithmetic for parent and children.
	always_comb begin
		parent_idx = (idx_q - 1'b1) >> 1;
		left_w     = {idx_q, 1'b1};
		right_w    = left_w + 1'b1;
		count_w    = {1'b0, count_q};
		has_left   = (left_w < count_w);
		has_right  = (right_w < count_w);
	end

	// Operand steering for the shared comparator.
	always_comb begin
		cmp_a = '0;
		cmp_b = '0;
		case (state_q)
			ST_IDLE: begin
				cmp_a = FRESH_LIMIT;
				cmp_b = fresh_q;
			end
			ST_GB_CHK: begin
				cmp_a = {1'b0, key_q};
				cmp_b = fresh_q;
			end
			ST_UP_CMP: begin
				cmp_a = {1'b0, key_q};
				cmp_b = {1'b0, mem_rsp.heap_rdata};
			end
			ST_DN_R: begin
				cmp_a = {1'b0, mem_rsp.heap_rdata};
				cmp_b = {1'b0, key_q};
			end
			ST_DN_CMP: begin
				cmp_a = {1'b0, mem_rsp.heap_rdata};
				cmp_b = {1'b0, min_q};
			end
			default: begin
				cmp_a = '0;
				cmp_b = '0;
			end
		endcase
	end

	// Smaller of the hole key and the children seen so far.
	always_comb begin
		sel_v = key_q;
		sel_m = idx_q;
		if (state_q == ST_DN_R) begin
			sel_v = lt ? mem_rsp.heap_rdata : key_q;
			sel_m = lt ? left_w[ID_W-1:0] : idx_q;
		end else if (state_q == ST_DN_CMP) begin
			sel_v = lt ? mem_rsp.heap_rdata : min_q;
			sel_m = lt ? right_w[ID_W-1:0] : m_q;
		end
		sel_moves = (sel_m != idx_q);
		gb_ok     = (key_q != '0) && lt && !mem_rsp.mb_rdata;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and storage accesses.
	always_comb begin
		state_d            = state_q;
		mem_req.heap_we    = 1'b0;
		mem_req.heap_waddr = idx_q;
		mem_req.heap_wdata = key_q;
		mem_req.heap_raddr = '0;
		mem_req.mb_we      = 1'b0;
		mem_req.mb_waddr   = key_q;
		mem_req.mb_wdata   = 1'b0;
		mem_req.mb_raddr   = req.num;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.func == FUNC_GIVE) begin
						state_d = ST_GB_CHK;
					end else if (count_q != '0) begin
						state_d = ST_POP_TOP;
					end
				end
			end
			ST_GB_CHK: begin
				if (gb_ok) begin
					mem_req.mb_we    = 1'b1;
					mem_req.mb_wdata = 1'b1;
					state_d          = ST_UP_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_UP_RD: begin
				if (idx_q == '0) begin
					mem_req.heap_we = 1'b1;
					state_d         = ST_IDLE;
				end else begin
					mem_req.heap_raddr = parent_idx;
					state_d            = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				mem_req.heap_we = 1'b1;
				if (lt) begin
					mem_req.heap_wdata = mem_rsp.heap_rdata;
					state_d            = ST_UP_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_POP_TOP: begin
				mem_req.mb_we    = 1'b1;
				mem_req.mb_waddr = mem_rsp.heap_rdata;
				if (count_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					mem_req.heap_raddr = count_q;
					state_d            = ST_POP_LAST;
				end
			end
			ST_POP_LAST: begin
				state_d = ST_DN_L;
			end
			ST_DN_L: begin
				if (has_left) begin
					mem_req.heap_raddr = left_w[ID_W-1:0];
					state_d            = ST_DN_R;
				end else begin
					mem_req.heap_we = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_DN_R: begin
				if (has_right) begin
					mem_req.heap_raddr = right_w[ID_W-1:0];
					state_d            = ST_DN_CMP;
				end else begin
					mem_req.heap_we    = 1'b1;
					mem_req.heap_wdata = sel_v;
					state_d            = sel_moves ? ST_DN_L : ST_IDLE;
				end
			end
			ST_DN_CMP: begin
				mem_req.heap_we    = 1'b1;
				mem_req.heap_wdata = sel_v;
				state_d            = sel_moves ? ST_DN_L : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Counter, heap size and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= FRESH_RESET;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (req.func == FUNC_POP)) begin
						if (count_q != '0) begin
							count_q <= count_q - 1'b1;
						end else begin
							done_q <= 1'b1;
							if (lt) begin
								fresh_q <= FRESH_SAT;
							end else begin
								fresh_q <= fresh_q + 1'b1;
							end
						end
					end
				end
				ST_GB_CHK: begin
					if (gb_ok) begin
						count_q <= count_q + 1'b1;
					end
				end
				ST_POP_TOP: begin
					done_q <= 1'b1;
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

	// Working registers of the sift and the result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					key_q <= req.num;
					if (lt) begin
						result_q.value     <= '0;
						result_q.exhausted <= 1'b1;
					end else begin
						result_q.value     <= fresh_q[ID_W-1:0];
						result_q.exhausted <= 1'b0;
					end
				end
			end
			ST_GB_CHK: begin
				idx_q <= count_q;
			end
			ST_UP_CMP: begin
				if (lt) begin
					idx_q <= parent_idx;
				end
			end
			ST_POP_TOP: begin
				result_q.value     <= mem_rsp.heap_rdata;
				result_q.exhausted <= 1'b0;
			end
			ST_POP_LAST: begin
				key_q <= mem_rsp.heap_rdata;
				idx_q <= '0;
			end
			ST_DN_R: begin
				min_q <= sel_v;
				m_q   <= sel_m;
				if (!has_right && sel_moves) begin
					idx_q <= sel_m;
				end
			end
			ST_DN_CMP: begin
				if (sel_moves) begin
					idx_q <= sel_m;
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

`ifndef SYNTHESIS
	// The heap never holds more entries than there are identifiers.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ID_W'(HEAP_DEPTH))
		else $error("heap count beyond capacity");

	// An exhausted result comes only from an empty heap and a saturated counter.
	a_exhausted_state: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.exhausted |-> (count_q == '0) && (fresh_q == FRESH_SAT)
			&& (result.value == '0))
		else $error("exhausted result with identifiers still free");

	// The fresh counter never moves backward.
	a_fresh_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		##1 fresh_q >= $past(fresh_q))
		else $error("fresh counter decreased");

	// A give-back check never leads to a result transfer.
	a_give_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GB_CHK |=> !done)
		else $error("result produced by a give-back");
`endif

endmodule
`default_nettype wire

### bench/smallest_free_id_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smallest free ID allocator testbench
// Sends pop and give-back requests to the allocator and predicts every pop
// from a membership map of returned identifiers and a fresh counter. Each
// result transfer is checked against the oldest pending prediction. Directed
// tests cover the first identifiers, every give-back filter, heap ordering
// and exhaustion. Random fill and drain bursts run under several sender
// idle rates, one before the exhaustion test and two after it.
// ----------------------------------------------------------------------------
module smallest_free_id_allocator_core_tb;
	import sfa_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 64;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	sfa_req_t req;
	logic     done;
	sfa_rsp_t result;

	// Predicted allocator state.
	int       next_fresh = int'(FRESH_RESET);
	bit       held_ids [MB_DEPTH];
	int       held_count = 0;
	sfa_rsp_t pending_ids [$];

	int mismatches = 0;
	int cycle_count = 0;

	smallest_free_id_allocator_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	always #4 clk = ~clk;

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	// Applies one accepted request to the predicted state. Returns 1 when the
	// request changes the state or produces a result.
	function automatic bit predict_allocation(input logic f, input logic [ID_W-1:0] n);
		sfa_rsp_t r;
		int       k;
		if (f == FUNC_GIVE) begin
			if (n != 0 && n < next_fresh && !held_ids[n]) begin
				held_ids[n] = 1'b1;
				held_count++;
				return 1'b1;
			end
			return 1'b0;
		end
		r.exhausted = 1'b0;
		if (held_count != 0) begin
			// The smallest returned identifier goes out first.
			k = 1;
			while (!held_ids[k])
				k++;
			held_ids[k] = 1'b0;
			held_count--;
			r.value = ID_W'(k);
		end else if (next_fresh > MAX_VALUE) begin
			r.value = '0;
			r.exhausted = 1'b1;
		end else begin
			r.value = ID_W'(next_fresh);
			next_fresh++;
		end
		pending_ids.push_back(r);
		return 1'b1;
	endfunction

	// Presents one request from a falling edge until it is accepted, then
	// predicts it at the next falling edge. Start is left high.
	task automatic send_req(input logic f, input logic [ID_W-1:0] n, output bit effective);
		start = 1'b1;
		req.func = f;
		req.num = n;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
		effective = predict_allocation(f, n);
	endtask

	// Keeps start low for each cycle in which the sender chooses to idle.
	task automatic idle_gap(input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic test_fresh_pops();
		bit eff;
		send_req(FUNC_POP, '0, eff);
		send_req(FUNC_POP, '1, eff);
		send_req(FUNC_POP, ID_W'(10'h2AA), eff);
		send_req(FUNC_POP, ID_W'(10'h155), eff);
	endtask

	task automatic test_give_back_filters();
		bit eff;
		// Zero, not yet handed out, out of reach and duplicate give-backs are dropped.
		send_req(FUNC_GIVE, '0, eff);
		send_req(FUNC_GIVE, ID_W'(9), eff);
		send_req(FUNC_GIVE, '1, eff);
		send_req(FUNC_GIVE, ID_W'(3), eff);
		send_req(FUNC_GIVE, ID_W'(3), eff);
		send_req(FUNC_GIVE, ID_W'(1), eff);
		send_req(FUNC_POP, '0, eff);
		send_req(FUNC_POP, '0, eff);
		send_req(FUNC_POP, '0, eff);
	endtask

	task automatic test_heap_order();
		bit eff;
		// Descending give-backs force sift-up to the root every time.
		for (int i = 5; i >= 1; i--)
			send_req(FUNC_GIVE, ID_W'(i), eff);
		repeat (6) send_req(FUNC_POP, '0, eff);
	endtask

	task automatic test_exhaustion();
		bit eff;
		// Pop until every identifier is out, then keep popping past the end.
		while (next_fresh <= MAX_VALUE || held_count != 0) begin
			send_req(FUNC_POP, ID_W'($urandom), eff);
			idle_gap(3);
		end
		send_req(FUNC_POP, '0, eff);
		send_req(FUNC_POP, '1, eff);
		// The saturated counter still accepts every identifier back.
		send_req(FUNC_GIVE, ID_W'(MAX_VALUE), eff);
		send_req(FUNC_GIVE, ID_W'(1), eff);
		send_req(FUNC_GIVE, '0, eff);
		send_req(FUNC_GIVE, ID_W'(MAX_VALUE), eff);
		repeat (3) send_req(FUNC_POP, '0, eff);
	endtask

	// Fill and drain bursts with random content; most give-backs name an
	// identifier that has already been handed out.
	task automatic test_random_mix(input int idle_pct, input int quota);
		int   count;
		int   burst_left;
		int   pop_pct;
		int   sel;
		logic f;
		logic [ID_W-1:0] n;
		bit   eff;
		count = 0;
		burst_left = 0;
		pop_pct = 50;
		while (count < quota) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(4, 160);
				sel = $urandom_range(2);
				pop_pct = (sel == 0) ? 15 : (sel == 1) ? 85 : 50;
			end
			burst_left--;
			f = ($urandom_range(99) < pop_pct) ? FUNC_POP : FUNC_GIVE;
			sel = $urandom_range(99);
			if (f == FUNC_POP || sel >= 80)
				n = ID_W'($urandom);
			else if (sel < 70 && next_fresh > 1)
				n = ID_W'($urandom_range(next_fresh - 1, 1));
			else
				n = '0;
			send_req(f, n, eff);
			if (eff)
				count++;
			idle_gap(idle_pct);
		end
	endtask

	// Checks each result transfer against the oldest prediction.
	always @(posedge clk) begin : check_results
		sfa_rsp_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_ids.size() == 0) begin
				report_mismatch($sformatf("unexpected result value %0d", result.value));
			end else begin
				want = pending_ids.pop_front();
				if (result.value !== want.value)
					report_mismatch($sformatf("value %0d, expected %0d",
						result.value, want.value));
				if (result.exhausted !== want.exhausted)
					report_mismatch($sformatf("exhausted %b, expected %b",
						result.exhausted, want.exhausted));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_fresh_pops();
		test_give_back_filters();
		test_heap_order();
		test_random_mix(26, 180);
		test_exhaustion();
		test_random_mix(71, 180);
		test_random_mix(0, 180);
		start = 1'b0;

		// Let the last results arrive, then watch for stray transfers.
		while (pending_ids.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
